@@ hdl/rszg_pkg.sv @@
// Package for the ring slider zoom gesture block.
// Holds button codes, slider ranges, level mapping constants and shared structs.
// No dependencies.
package rszg_pkg;

  // button codes: none and the four one-hot buttons
  localparam logic [3:0] BTN_NONE = 4'd0;
  localparam logic [3:0] BTN_1    = 4'd1;
  localparam logic [3:0] BTN_2    = 4'd2;
  localparam logic [3:0] BTN_4    = 4'd4;
  localparam logic [3:0] BTN_8    = 4'd8;

  // configuration register indexes
  localparam logic CFG_MOVE_THR = 1'b0;
  localparam logic CFG_IDLE_THR = 1'b1;

  // register reset values
  localparam logic [7:0] MOVE_THR_RST = 8'd5;
  localparam logic [7:0] IDLE_THR_RST = 8'd3;
  localparam logic [9:0] LAST_POS_RST = 10'd20;
  localparam logic [7:0] LAST_LVL_RST = 8'd1;

  // slider half bounds
  localparam logic [9:0] LO_POS_LIMIT = 10'd130;  // lower half below this
  localparam logic [9:0] UP_POS_FLOOR = 10'd150;  // upper half above this
  localparam logic [9:0] UP_POS_LIMIT = 10'd280;  // upper half below this

  // division by 130 done as multiply by 32264 and shift right by 22;
  // exact for numerators below 2^18
  localparam int unsigned RECIP_SHIFT = 22;
  // lower: (13000 - 99*pos) / 130
  localparam logic [21:0] LO_MUL  = 22'd3194136;
  localparam logic [29:0] LO_BASE = 30'd419432000;
  // upper: (100*pos - 700) / 130
  localparam logic [21:0] UP_MUL  = 22'd3226400;
  localparam logic [29:0] UP_OFS  = 30'd22584800;

  // level mapping result
  typedef struct packed {
    logic       have;
    logic [7:0] level;
  } rszg_map_t;

  // per-beat gesture result
  typedef struct packed {
    logic       emit;
    logic [7:0] level;
    logic [3:0] button;
    logic       zoom_out;
  } rszg_res_t;

endpackage

@@ hdl/rszg_level_map.sv @@
// Maps a slider position and button to a zoom level for either slider half.
// Depends on rszg_pkg.
module rszg_level_map (
  input  logic [9:0]          pos_i,
  input  logic [3:0]          btn_i,
  output rszg_pkg::rszg_map_t map_o
);
  import rszg_pkg::*;

  logic        lo_ok;
  logic        up_ok;
  logic [29:0] lo_prod;
  logic [29:0] lo_num;
  logic [29:0] up_prod;
  logic [29:0] up_num;
  logic [7:0]  lo_lvl;
  logic [7:0]  up_lvl;

  // range checks per half
  assign lo_ok = (pos_i < LO_POS_LIMIT) && (btn_i < BTN_4);
  assign up_ok = (pos_i > UP_POS_FLOOR) && (pos_i < UP_POS_LIMIT) && (btn_i >= BTN_4);

  // lower half, levels 100 down to 1
  assign lo_prod = 30'(LO_MUL * pos_i[7:0]);
  assign lo_num  = LO_BASE - lo_prod;
  assign lo_lvl  = lo_num[RECIP_SHIFT +: 8];

  // upper half, levels 110 to 209
  assign up_prod = 30'(UP_MUL * pos_i[8:0]);
  assign up_num  = up_prod - UP_OFS;
  assign up_lvl  = up_num[RECIP_SHIFT +: 8];

  // pick the half
  always_comb begin
    map_o.have  = (btn_i != BTN_NONE) && (lo_ok || up_ok);
    map_o.level = lo_ok ? lo_lvl : up_lvl;
  end

endmodule

@@ hdl/rszg_gesture.sv @@
// Gesture state: last position, last button, zoom direction flags, last level.
// Updates once per processed beat. Depends on rszg_pkg and rszg_level_map.
module rszg_gesture (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [9:0]          pos_i,
  input  logic [3:0]          btn_i,
  input  logic [7:0]          move_thr_i,
  input  logic [7:0]          idle_thr_i,
  output rszg_pkg::rszg_res_t res_o
);
  import rszg_pkg::*;

  logic [9:0] last_pos_q, last_pos_d;
  logic [3:0] last_btn_q, last_btn_d;
  logic       zin_q, zin_d;
  logic       zout_q, zout_d;
  logic [7:0] last_lvl_q, last_lvl_d;

  rszg_map_t  map;
  logic [10:0] pos_hi;
  logic [10:0] pos_lo;
  logic        moved;
  logic        armed;
  logic        accept;

  rszg_level_map u_map (
    .pos_i (pos_i),
    .btn_i (btn_i),
    .map_o (map)
  );

  // movement against the last position
  assign pos_hi = {1'b0, last_pos_q} + {3'b000, move_thr_i};
  assign pos_lo = {1'b0, pos_i} + {3'b000, move_thr_i};
  assign moved  = ({1'b0, pos_i} > pos_hi) || (pos_lo < {1'b0, last_pos_q});
  assign armed  = zin_q || zout_q;
  assign accept = zin_q ? (map.level > last_lvl_q) : (map.level < last_lvl_q);

  // result of this beat
  always_comb begin
    res_o.emit     = moved && armed && map.have && accept;
    res_o.level    = map.level;
    res_o.button   = btn_i;
    res_o.zoom_out = !zin_q;
  end

  // next state
  always_comb begin
    last_pos_d = last_pos_q;
    last_lvl_d = last_lvl_q;
    last_btn_d = last_btn_q;
    zin_d      = zin_q;
    zout_d     = zout_q;
    if (moved && armed) begin
      last_pos_d = pos_i;
      if (map.have) begin
        last_lvl_d = map.level;
      end
    end
    if ((pos_i < {2'b00, idle_thr_i}) && (btn_i == BTN_NONE)) begin
      zin_d      = 1'b0;
      zout_d     = 1'b0;
      last_btn_d = BTN_NONE;
    end else begin
      case (btn_i)
        BTN_8: begin
          if (last_btn_q == BTN_4) begin
            zin_d = 1'b1; zout_d = 1'b0;
          end else if (last_btn_q == BTN_2) begin
            zin_d = 1'b0; zout_d = 1'b1;
          end
          last_btn_d = BTN_8;
        end
        BTN_4: begin
          if (last_btn_q == BTN_1) begin
            zin_d = 1'b1; zout_d = 1'b0;
          end else if (last_btn_q == BTN_8) begin
            zin_d = 1'b0; zout_d = 1'b1;
          end
          last_btn_d = BTN_4;
        end
        BTN_2: begin
          if (last_btn_q == BTN_4) begin
            zin_d = 1'b1; zout_d = 1'b0;
          end else if (last_btn_q == BTN_1) begin
            zin_d = 1'b0; zout_d = 1'b1;
          end
          last_btn_d = BTN_2;
        end
        BTN_1: begin
          if (last_btn_q == BTN_2) begin
            zin_d = 1'b1; zout_d = 1'b0;
          end else if (last_btn_q == BTN_4) begin
            zin_d = 1'b0; zout_d = 1'b1;
          end
          last_btn_d = BTN_1;
        end
        default: begin
          // not one-hot: state kept
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q <= LAST_POS_RST;
      last_btn_q <= BTN_NONE;
      zin_q      <= 1'b0;
      zout_q     <= 1'b0;
      last_lvl_q <= LAST_LVL_RST;
    end else if (step_i) begin
      last_pos_q <= last_pos_d;
      last_btn_q <= last_btn_d;
      zin_q      <= zin_d;
      zout_q     <= zout_d;
      last_lvl_q <= last_lvl_d;
    end
  end

endmodule

@@ hdl/ring_slider_zoom_gesture.sv @@
// Ring slider zoom gesture detector, top level.
// A sample's level reaches the outputs through the input register and then the result register.
// Throughput: one sample per cycle; the input register and the result register
// form a two-stage pipeline, and a held result stalls the input only when both are full.
// Reset (rst_ni, asynchronous, active low) restores thresholds 5 and 3 and the gesture state.
// Depends on rszg_pkg and rszg_gesture.
module ring_slider_zoom_gesture (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // sample channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [9:0] slider_position_i,
  input  logic [3:0] button_status_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] zoom_level_o,
  output logic [3:0] touched_button_o,
  output logic       zoom_out_o
);
  import rszg_pkg::*;

  logic [7:0] move_thr_q;
  logic [7:0] idle_thr_q;

  logic       s1_valid_q;
  logic [9:0] s1_pos_q;
  logic [3:0] s1_btn_q;
  logic       s1_fire;
  logic       in_acc;

  logic       out_valid_q;
  logic [7:0] out_level_q;
  logic [3:0] out_btn_q;
  logic       out_dir_q;

  rszg_res_t  res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_thr_q <= MOVE_THR_RST;
      idle_thr_q <= IDLE_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MOVE_THR: move_thr_q <= cfg_data_i;
        CFG_IDLE_THR: idle_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  assign s1_fire    = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pos_q <= slider_position_i;
      s1_btn_q <= button_status_i;
    end
  end

  rszg_gesture u_gesture (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_fire),
    .pos_i      (s1_pos_q),
    .btn_i      (s1_btn_q),
    .move_thr_i (move_thr_q),
    .idle_thr_i (idle_thr_q),
    .res_o      (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= res.emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && res.emit) begin
      out_level_q <= res.level;
      out_btn_q   <= res.button;
      out_dir_q   <= res.zoom_out;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign zoom_level_o     = out_level_q;
  assign touched_button_o = out_btn_q;
  assign zoom_out_o       = out_dir_q;

  // checks
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_level_q >= 8'd1 && out_level_q <= 8'd100) ||
                     (out_level_q >= 8'd110 && out_level_q <= 8'd209)))
    else $error("emitted zoom level outside both slider ranges");

  a_button_touched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_btn_q != BTN_NONE))
    else $error("emitted level without a touched button");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_level_q)))
    else $error("stalled result lost or changed by a new sample");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for ring_slider_zoom_gesture.
// Drives touch samples and register writes, predicts the zoom levels and checks every result beat.
// Depends on rszg_pkg and the ring_slider_zoom_gesture RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rszg_pkg::*;

  // one expected result beat
  typedef struct packed {
    logic [7:0] level;
    logic [3:0] button;
    logic       zoom_out;
  } zoom_result_t;

  // gesture state tracker and queue of expected levels
  class zoom_scoreboard;
    logic [7:0]   move_thr;
    logic [7:0]   idle_thr;
    logic [9:0]   last_pos;
    logic [3:0]   last_btn;
    bit           zoom_in_armed;
    bit           zoom_out_armed;
    logic [7:0]   last_level;
    bit           accept;
    zoom_result_t pending[$];
    int           errors;

    function new();
      move_thr       = MOVE_THR_RST;
      idle_thr       = IDLE_THR_RST;
      last_pos       = LAST_POS_RST;
      last_btn       = BTN_NONE;
      zoom_in_armed  = 1'b0;
      zoom_out_armed = 1'b0;
      last_level     = LAST_LVL_RST;
      accept         = 1'b0;
      errors         = 0;
    endfunction

    function void set_reg(logic idx, logic [7:0] value);
      if (idx == CFG_MOVE_THR) move_thr = value;
      else idle_thr = value;
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    function void arm_zoom(bit zoom_in);
      zoom_in_armed  = zoom_in;
      zoom_out_armed = !zoom_in;
    endfunction

    // next gesture state for one sample; returns 1 when a level is emitted
    function bit predict_gesture(logic [9:0] pos, logic [3:0] btn, output zoom_result_t res);
      int unsigned p;
      int unsigned lvl;
      bit          moved;
      bit          fits;
      bit          emit;
      p     = pos;
      lvl   = 0;
      fits  = 1'b0;
      emit  = 1'b0;
      res   = '0;
      moved = (p > last_pos + move_thr) || (p + move_thr < last_pos);

      // move check and level mapping with the flags from before this sample
      if (moved && (zoom_in_armed || zoom_out_armed)) begin
        res.zoom_out = !zoom_in_armed;
        if (btn != BTN_NONE) begin
          if (p < LO_POS_LIMIT && btn < BTN_4) begin
            lvl  = ((130 - p) * 99 + 130) / 130;
            fits = 1'b1;
          end else if (p > UP_POS_FLOOR && p < UP_POS_LIMIT && btn >= BTN_4) begin
            lvl  = (100 * p + 210 * 130 - 28000) / 130;
            fits = 1'b1;
          end
        end
        if (!fits) begin
          accept = 1'b0;
        end else begin
          accept     = zoom_in_armed ? (lvl > last_level) : (lvl < last_level);
          last_level = lvl[7:0];
        end
        emit       = accept && btn != BTN_NONE;
        res.level  = last_level;
        res.button = btn;
        last_pos   = pos;
      end

      // idle touch and button transitions
      if (p < idle_thr && btn == BTN_NONE) begin
        zoom_in_armed  = 1'b0;
        zoom_out_armed = 1'b0;
        last_btn       = BTN_NONE;
      end else begin
        case (btn)
          BTN_8: begin
            if (last_btn == BTN_4) arm_zoom(1'b1);
            else if (last_btn == BTN_2) arm_zoom(1'b0);
            last_btn = btn;
          end
          BTN_4: begin
            if (last_btn == BTN_1) arm_zoom(1'b1);
            else if (last_btn == BTN_8) arm_zoom(1'b0);
            last_btn = btn;
          end
          BTN_2: begin
            if (last_btn == BTN_4) arm_zoom(1'b1);
            else if (last_btn == BTN_1) arm_zoom(1'b0);
            last_btn = btn;
          end
          BTN_1: begin
            if (last_btn == BTN_2) arm_zoom(1'b1);
            else if (last_btn == BTN_4) arm_zoom(1'b0);
            last_btn = btn;
          end
          default: ;
        endcase
      end
      return emit;
    endfunction

    function void note_sample(logic [9:0] pos, logic [3:0] btn);
      zoom_result_t res;
      if (predict_gesture(pos, btn, res)) pending.push_back(res);
    endfunction

    task check_result(logic [7:0] lvl, logic [3:0] btn, logic zo);
      zoom_result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected level %0d button %0d", lvl, btn));
        return;
      end
      want = pending.pop_front();
      if (lvl !== want.level)
        report_mismatch($sformatf("zoom_level got %0d want %0d", lvl, want.level));
      if (btn !== want.button)
        report_mismatch($sformatf("touched_button got %0d want %0d", btn, want.button));
      if (zo !== want.zoom_out)
        report_mismatch($sformatf("zoom_out got %0d want %0d", zo, want.zoom_out));
    endtask
  endclass

  logic       clk_i             = 1'b0;
  logic       rst_ni            = 1'b0;
  logic       cfg_we_i          = 1'b0;
  logic       cfg_index_i       = 1'b0;
  logic [7:0] cfg_data_i        = '0;
  logic       in_valid_i        = 1'b0;
  logic       in_stall_o;
  logic [9:0] slider_position_i = '0;
  logic [3:0] button_status_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i       = 1'b0;
  logic [7:0] zoom_level_o;
  logic [3:0] touched_button_o;
  logic       zoom_out_o;

  zoom_scoreboard sb;
  int             samples_sent = 0;
  bit             steady_flow  = 1'b0;

  // button pairs that arm a gesture: first four zoom in, last four zoom out
  logic [3:0] arm_from [8] = '{BTN_4, BTN_1, BTN_4, BTN_2, BTN_2, BTN_8, BTN_1, BTN_4};
  logic [3:0] arm_to   [8] = '{BTN_8, BTN_4, BTN_2, BTN_1, BTN_8, BTN_4, BTN_2, BTN_1};
  logic [3:0] one_hot  [4] = '{BTN_1, BTN_2, BTN_4, BTN_8};

  // per-phase register settings; the last phase is random
  logic [7:0] phase_move [6] = '{8'd5, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0};
  logic [7:0] phase_idle [6] = '{8'd3, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};

  ring_slider_zoom_gesture DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .slider_position_i(slider_position_i),
    .button_status_i  (button_status_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .zoom_level_o     (zoom_level_o),
    .touched_button_o (touched_button_o),
    .zoom_out_o       (zoom_out_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // result side stalls
  initial begin : result_stall
    int n;
    forever begin
      n = pick_gap();
      out_stall_i = (n != 0);
      repeat (n) @(negedge clk_i);
      out_stall_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  end

  // result beat check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(zoom_level_o, touched_button_o, zoom_out_o);
  end

  // one sample beat; returns at the falling edge after acceptance
  task automatic send_sample(input logic [9:0] pos, input logic [3:0] btn);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    slider_position_i = pos;
    button_status_i   = btn;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(pos, btn);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // wait until every expected level is out and the pipeline is empty
  task automatic settle_block();
    int waited;
    waited     = 0;
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0 && waited < 4000) begin
      @(negedge clk_i);
      waited++;
    end
    if (sb.pending.size() != 0) begin
      sb.report_mismatch($sformatf("%0d levels never arrived", sb.pending.size()));
      sb.pending.delete();
    end
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, value);
  endtask

  // slider position, mostly inside the half that suits the button
  function automatic logic [9:0] slide_position(logic [3:0] btn);
    if ($urandom_range(0, 9) == 0) return 10'($urandom_range(0, 1023));
    if (btn < BTN_4) return 10'($urandom_range(0, 129));
    return 10'($urandom_range(151, 279));
  endfunction

  // arm a gesture, slide, and sometimes let go of the ring
  task automatic run_gesture();
    int         k;
    logic [3:0] slide_btn;
    logic [9:0] pos;
    k   = $urandom_range(0, 7);
    pos = 10'($urandom_range(0, 1023));
    send_sample(pos, arm_from[k]);
    send_sample(pos, arm_to[k]);
    repeat ($urandom_range(2, 10)) begin
      if ($urandom_range(0, 9) < 7) slide_btn = arm_to[k];
      else slide_btn = one_hot[$urandom_range(0, 3)];
      send_sample(slide_position(slide_btn), slide_btn);
    end
    if ($urandom_range(0, 2) == 0 && sb.idle_thr != 0)
      send_sample(10'($urandom_range(0, sb.idle_thr - 1)), BTN_NONE);
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 4))
      send_sample(10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)));
  endtask

  // directed samples at reset thresholds
  task automatic run_directed();
    send_sample(10'd1023, BTN_NONE);
    send_sample(10'd0,    BTN_NONE);   // idle touch
    send_sample(10'd100,  BTN_1);
    send_sample(10'd100,  BTN_2);      // arms zoom out
    send_sample(10'd0,    BTN_2);      // lower end, level 100, no fall
    send_sample(10'd129,  BTN_2);      // level 1 emitted
    send_sample(10'd200,  BTN_4);      // upper half under a zoom out
    send_sample(10'd200,  BTN_8);      // arms zoom in
    send_sample(10'd151,  BTN_8);      // level 110
    send_sample(10'd279,  BTN_8);      // level 209 emitted
    send_sample(10'd150,  BTN_8);      // just below the upper half
    send_sample(10'd280,  BTN_8);      // just above the upper half
    send_sample(10'd130,  BTN_1);      // just above the lower half
    send_sample(10'd60,   4'hf);       // not one-hot
    send_sample(10'd40,   4'h3);       // not one-hot, maps to the lower half
    send_sample(10'd2,    BTN_NONE);   // idle touch at the threshold edge
    send_sample(10'd3,    BTN_NONE);   // not idle
    // walk every arming pair but BTN_4 to BTN_8
    send_sample(10'd3, BTN_1);
    send_sample(10'd3, BTN_4);
    send_sample(10'd3, BTN_2);
    send_sample(10'd3, BTN_8);
    send_sample(10'd3, BTN_4);
    send_sample(10'd3, BTN_1);
    send_sample(10'd3, BTN_2);
    send_sample(10'd3, BTN_1);
  endtask

  // run limit
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // main sequence
  initial begin : stimulus
    int quota;
    sb = new();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    run_directed();
    for (int ph = 0; ph < 6; ph++) begin
      steady_flow = 1'b0;
      if (ph > 0) begin
        settle_block();
        if (ph == 5) begin
          phase_move[ph] = 8'($urandom_range(0, 40));
          phase_idle[ph] = 8'($urandom_range(0, 255));
        end
        write_reg(CFG_MOVE_THR, phase_move[ph]);
        write_reg(CFG_IDLE_THR, phase_idle[ph]);
      end
      steady_flow = (ph == 2);
      quota = samples_sent + 235;
      while (samples_sent < quota) begin
        if ($urandom_range(0, 3) != 0) run_gesture();
        else run_noise();
      end
    end
    steady_flow = 1'b0;
    settle_block();
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
